// ===== hdl/pngu_pkg.sv =====
// Shared types and constants for the PNG scanline unfilter.
// Used by pngu_front, pngu_back and png_scanline_unfilter. No dependencies.
package pngu_pkg;

    localparam int PIX_MAX   = 8;    // widest pixel, in bytes
    localparam int SLOT_W    = 3;    // index into the left / up-left windows
    localparam int BPP_W     = 4;
    localparam int BPL_W     = 13;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_BPP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_BPL = CFG_IDX_W'(1);

    typedef logic [2:0] filter_t;

    localparam filter_t FT_NONE  = 3'd0;
    localparam filter_t FT_SUB   = 3'd1;
    localparam filter_t FT_UP    = 3'd2;
    localparam filter_t FT_AVG   = 3'd3;
    localparam filter_t FT_PAETH = 3'd4;

    // One data byte as classified by the front end.
    typedef struct packed {
        logic [7:0]        value;
        filter_t           filter;
        logic              invalid;
        logic              first_row;
        logic              has_left;   // left neighbor exists and was written in this row
        logic              last;
        logic [SLOT_W-1:0] slot;       // column modulo bytes per pixel
    } item_meta_t;

endpackage

// ===== hdl/pngu_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pngu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== hdl/pngu_front.sv =====
// Front end: accepts stream words, latches filter-type bytes, tracks the column
// and classifies data bytes for the back end. Depends on pngu_pkg.
module pngu_front #(
    parameter int MAX_LINE_BYTES = 4096,
    parameter int IDX_W          = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  byte_value,
    input  logic                        image_start,
    input  logic [pngu_pkg::BPP_W-1:0]  bpp_cfg,
    input  logic [pngu_pkg::BPL_W-1:0]  bpl_cfg,
    input  logic                        q_full,
    output logic                        push,
    output pngu_pkg::item_meta_t        push_meta,
    output logic [IDX_W-1:0]            push_idx
);
    import pngu_pkg::*;

    localparam int COL_W = $clog2(MAX_LINE_BYTES + 1);
    localparam int CMP_W = (COL_W > BPL_W) ? COL_W : BPL_W;
    localparam int LFT_W = (COL_W > BPP_W) ? COL_W : BPP_W;

    logic [COL_W-1:0]   col_reg, col_next;
    // mod_reg[k] holds the next data index modulo k + 1
    logic [SLOT_W-1:0]  mod_reg  [PIX_MAX];
    logic [SLOT_W-1:0]  mod_next [PIX_MAX];
    logic [PIX_MAX-1:0] seen_reg, seen_next;
    logic               first_row_reg, first_row_next;
    filter_t            filter_reg, filter_next;
    logic               invalid_reg, invalid_next;

    logic               accept;
    logic               first_row_eff;
    logic [COL_W-1:0]   col_eff;
    logic [BPP_W-1:0]   bpp_eff;
    logic [CMP_W-1:0]   bpl_ext, bpl_eff, max_ext;
    logic               last;
    logic [SLOT_W-1:0]  bpp_sel;
    logic [SLOT_W-1:0]  slot;
    logic               has_left;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign first_row_eff = image_start ? 1'b1 : first_row_reg;
    assign col_eff       = image_start ? '0 : col_reg;

    always_comb
    begin
        if (bpp_cfg == '0)
            bpp_eff = BPP_W'(1);
        else if (bpp_cfg > BPP_W'(PIX_MAX))
            bpp_eff = BPP_W'(PIX_MAX);
        else
            bpp_eff = bpp_cfg;
    end

    assign bpl_ext = CMP_W'(bpl_cfg);
    assign max_ext = CMP_W'(MAX_LINE_BYTES);

    always_comb
    begin
        if (bpl_ext == '0)
            bpl_eff = CMP_W'(1);
        else if (bpl_ext > max_ext)
            bpl_eff = max_ext;
        else
            bpl_eff = bpl_ext;
    end

    // col holds data index + 1, so the row ends once col reaches the line length
    assign last     = CMP_W'(col_eff) >= bpl_eff;
    assign bpp_sel  = SLOT_W'(bpp_eff - BPP_W'(1));
    assign slot     = mod_reg[bpp_sel];
    // window slots not written since the filter byte read as zero
    assign has_left = (LFT_W'(col_eff) > LFT_W'(bpp_eff)) && seen_reg[slot];

    assign push                = accept && (col_eff != '0);
    assign push_idx            = IDX_W'(col_eff - COL_W'(1));
    assign push_meta.value     = byte_value;
    assign push_meta.filter    = filter_reg;
    assign push_meta.invalid   = invalid_reg;
    assign push_meta.first_row = first_row_eff;
    assign push_meta.has_left  = has_left;
    assign push_meta.last      = last;
    assign push_meta.slot      = slot;

    always_comb
    begin
        col_next       = col_reg;
        seen_next      = seen_reg;
        first_row_next = first_row_reg;
        filter_next    = filter_reg;
        invalid_next   = invalid_reg;
        for (int k = 0; k < PIX_MAX; k++)
        begin
            mod_next[k] = mod_reg[k];
        end
        if (accept)
        begin
            first_row_next = first_row_eff;
            if (col_eff == '0)
            begin
                if (byte_value > {5'd0, FT_PAETH})
                begin
                    filter_next  = FT_NONE;
                    invalid_next = 1'b1;
                end
                else
                begin
                    filter_next  = byte_value[2:0];
                    invalid_next = 1'b0;
                end
                col_next  = COL_W'(1);
                seen_next = '0;
                for (int k = 0; k < PIX_MAX; k++)
                begin
                    mod_next[k] = '0;
                end
            end
            else
            begin
                if (last)
                begin
                    col_next       = '0;
                    first_row_next = 1'b0;
                end
                else
                begin
                    col_next = col_eff + COL_W'(1);
                end
                seen_next[slot] = 1'b1;
                for (int k = 0; k < PIX_MAX; k++)
                begin
                    mod_next[k] = (mod_reg[k] == SLOT_W'(k)) ? '0 : mod_reg[k] + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            seen_reg      <= '0;
            first_row_reg <= 1'b1;
            filter_reg    <= FT_NONE;
            invalid_reg   <= 1'b0;
            for (int k = 0; k < PIX_MAX; k++)
            begin
                mod_reg[k] <= '0;
            end
        end
        else
        begin
            col_reg       <= col_next;
            seen_reg      <= seen_next;
            first_row_reg <= first_row_next;
            filter_reg    <= filter_next;
            invalid_reg   <= invalid_next;
            for (int k = 0; k < PIX_MAX; k++)
            begin
                mod_reg[k] <= mod_next[k];
            end
        end
    end

endmodule

// ===== hdl/pngu_queue.sv =====
// Small FIFO between front and back end, flop storage, head shown combinationally.
// No dependencies.
module pngu_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hdl/pngu_back.sv =====
// Back end: reads the line store, forms the None/Sub/Up/Average/Paeth predictor
// and registers the result word. Depends on pngu_pkg and pngu_ram.
module pngu_back #(
    parameter int MAX_LINE_BYTES = 4096,
    parameter int IDX_W          = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  pngu_pkg::item_meta_t q_meta,
    input  logic [IDX_W-1:0]     q_idx,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           pixel_byte,
    output logic                 row_end,
    output logic                 bad_filter
);
    import pngu_pkg::*;

    function automatic logic [9:0] abs10(input logic signed [9:0] x);
        abs10 = x[9] ? 10'(-x) : 10'(x);
    endfunction

    // stage 1: item whose line-store read is in flight
    logic             s1_valid_reg;
    item_meta_t       s1_meta_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             fwd_hit_reg;
    logic [7:0]       fwd_data_reg;
    logic [7:0]       ram_rdata;

    logic [7:0] left_win_reg   [PIX_MAX];
    logic [7:0] upleft_win_reg [PIX_MAX];

    logic       out_valid_reg;
    logic [7:0] pixel_byte_reg;
    logic       row_end_reg;
    logic       bad_filter_reg;

    logic                advance;
    logic [7:0]          a, b, c, up_raw, pred, res;
    logic [8:0]          sum_ab;
    logic signed [9:0]   a_s, b_s, c_s, p_s;
    logic [9:0]          pa, pb, pc;
    logic [7:0]          paeth;

    assign advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign q_pop   = q_valid && (!s1_valid_reg || advance);

    pngu_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE_BYTES)
    ) u_line (
        .clk   (clk),
        .we    (advance),
        .waddr (s1_idx_reg),
        .wdata (res),
        .re    (q_pop),
        .raddr (q_idx),
        .rdata (ram_rdata)
    );

    // same column written and read on one edge: the RAM returns stale data
    assign up_raw = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    assign a = s1_meta_reg.has_left ? left_win_reg[s1_meta_reg.slot] : 8'd0;
    assign b = s1_meta_reg.first_row ? 8'd0 : up_raw;
    assign c = (s1_meta_reg.has_left && !s1_meta_reg.first_row)
             ? upleft_win_reg[s1_meta_reg.slot] : 8'd0;

    assign sum_ab = {1'b0, a} + {1'b0, b};

    assign a_s = signed'({2'b00, a});
    assign b_s = signed'({2'b00, b});
    assign c_s = signed'({2'b00, c});
    assign p_s = a_s + b_s - c_s;
    assign pa  = abs10(p_s - a_s);
    assign pb  = abs10(p_s - b_s);
    assign pc  = abs10(p_s - c_s);

    always_comb
    begin
        if (pa <= pb && pa <= pc)
            paeth = a;
        else if (pb <= pc)
            paeth = b;
        else
            paeth = c;
    end

    always_comb
    begin
        case (s1_meta_reg.filter)
            FT_SUB:   pred = a;
            FT_UP:    pred = b;
            FT_AVG:   pred = sum_ab[8:1];
            FT_PAETH: pred = paeth;
            default:  pred = 8'd0;
        endcase
    end

    assign res = s1_meta_reg.value + pred;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < PIX_MAX; i++)
            begin
                left_win_reg[i]   <= 8'd0;
                upleft_win_reg[i] <= 8'd0;
            end
        end
        else
        begin
            if (q_pop)
                s1_valid_reg <= 1'b1;
            else if (advance)
                s1_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                left_win_reg[s1_meta_reg.slot]   <= res;
                upleft_win_reg[s1_meta_reg.slot] <= b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_meta_reg  <= q_meta;
            s1_idx_reg   <= q_idx;
            fwd_hit_reg  <= advance && (s1_idx_reg == q_idx);
            fwd_data_reg <= res;
        end
        if (advance)
        begin
            pixel_byte_reg <= res;
            row_end_reg    <= s1_meta_reg.last;
            bad_filter_reg <= s1_meta_reg.invalid;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pixel_byte = pixel_byte_reg;
    assign row_end    = row_end_reg;
    assign bad_filter = bad_filter_reg;

endmodule

// ===== hdl/png_scanline_unfilter.sv =====
// PNG scanline unfilter: one byte per unstalled cycle, filter-type bytes give no word.
// Path: a data byte passes the queue, the line-store read, the predictor and the
// output register; a low out_ready holds it back.
// Throughput: one byte per unstalled cycle, set by the predictor and left-byte loop.
// Reset: control state and windows clear at once; the line store is not cleared,
// registers return to bytes_per_pixel = 1 and bytes_per_line = 1.
module png_scanline_unfilter #(
    parameter int MAX_LINE_BYTES = 4096
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     byte_value,
    input  logic                           image_start,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     pixel_byte,
    output logic                           row_end,
    output logic                           bad_filter,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pngu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pngu_pkg::BPL_W-1:0]     cfg_data
);
    import pngu_pkg::*;

    localparam int IDX_W  = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    localparam int META_W = $bits(item_meta_t);
    localparam int Q_W    = META_W + IDX_W;

    logic [BPP_W-1:0] bpp_reg;
    logic [BPL_W-1:0] bpl_reg;

    logic             q_full, q_push, q_pop, q_valid;
    item_meta_t       push_meta, head_meta;
    logic [IDX_W-1:0] push_idx, head_idx;
    logic [Q_W-1:0]   head_word;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg <= BPP_W'(1);
            bpl_reg <= BPL_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_BPP: bpp_reg <= cfg_data[BPP_W-1:0];
                REG_BPL: bpl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pngu_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .IDX_W          (IDX_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .byte_value  (byte_value),
        .image_start (image_start),
        .bpp_cfg     (bpp_reg),
        .bpl_cfg     (bpl_reg),
        .q_full      (q_full),
        .push        (q_push),
        .push_meta   (push_meta),
        .push_idx    (push_idx)
    );

    pngu_queue #(
        .WIDTH (Q_W),
        .DEPTH (4)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  ({push_meta, push_idx}),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_data  (head_word)
    );

    assign head_meta = head_word[Q_W-1:IDX_W];
    assign head_idx  = head_word[IDX_W-1:0];

    pngu_back #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .IDX_W          (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_meta     (head_meta),
        .q_idx      (head_idx),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_byte (pixel_byte),
        .row_end    (row_end),
        .bad_filter (bad_filter)
    );

endmodule
